[rtl/tmon_pkg.sv]
// shared types and constants of the temperature threshold monitor
`default_nettype none

package tmon_pkg;

	localparam int SAMPLE_W = 12;
	localparam int BYTE_W   = 8;
	localparam int EVENT_W  = 4;
	localparam int TEMP_W   = 9;
	localparam int LEVEL_W  = 2;
	localparam int LIMIT_W  = 10;

	// event codes of a result beat
	localparam logic [EVENT_W-1:0] EV_SAMPLE     = 4'd0;
	localparam logic [EVENT_W-1:0] EV_REPORT     = 4'd1;
	localparam logic [EVENT_W-1:0] EV_STORED     = 4'd2;
	localparam logic [EVENT_W-1:0] EV_PROMPT_MAX = 4'd3;
	localparam logic [EVENT_W-1:0] EV_PROMPT_MIN = 4'd4;
	localparam logic [EVENT_W-1:0] EV_MAX_SET    = 4'd5;
	localparam logic [EVENT_W-1:0] EV_MIN_SET    = 4'd6;
	localparam logic [EVENT_W-1:0] EV_BAD_DIGITS = 4'd7;
	localparam logic [EVENT_W-1:0] EV_TOO_LONG   = 4'd8;

	// level codes
	localparam logic [LEVEL_W-1:0] LVL_BELOW = 2'd0;
	localparam logic [LEVEL_W-1:0] LVL_BAND  = 2'd1;
	localparam logic [LEVEL_W-1:0] LVL_ABOVE = 2'd2;

	// item kinds
	localparam logic MODE_SAMPLE = 1'b0;
	localparam logic MODE_BYTE   = 1'b1;

	// terminal characters
	localparam logic [BYTE_W-1:0] CHAR_MAX   = 8'h78;
	localparam logic [BYTE_W-1:0] CHAR_MIN   = 8'h6e;
	localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0a;
	localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'd48;
	localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'd57;

	// scaling and limits
	localparam int SCALE_MUL = 330;
	localparam int SCALE_DIV = 4095;
	localparam logic [LIMIT_W-1:0] LIMIT_TOP     = 10'd999;
	localparam logic [LIMIT_W-1:0] MAX_RESET_VAL = 10'd200;
	localparam logic [LIMIT_W-1:0] MIN_RESET_VAL = 10'd100;

endpackage

`default_nettype wire

[rtl/tmon_if.sv]
// valid/ready channel interfaces for input items and result beats
`default_nettype none

interface tmon_item_if import tmon_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                mode;
	logic [SAMPLE_W-1:0] sample;
	logic [BYTE_W-1:0]   rx_byte;

	modport source(output valid, mode, sample, rx_byte, input ready);
	modport sink(input valid, mode, sample, rx_byte, output ready);
endinterface

interface tmon_result_if import tmon_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [EVENT_W-1:0] event_res;
	logic [TEMP_W-1:0]  temperature;
	logic [LEVEL_W-1:0] level;
	logic               max_reached;
	logic               min_reached;
	logic [LIMIT_W-1:0] max_limit;
	logic [LIMIT_W-1:0] min_limit;

	modport source(output valid, event_res, temperature, level, max_reached, min_reached,
		max_limit, min_limit, input ready);
	modport sink(input valid, event_res, temperature, level, max_reached, min_reached,
		max_limit, min_limit, output ready);
endinterface

`default_nettype wire

[rtl/temperature_threshold_monitor_top.sv]
// temperature threshold monitor: sample scaling, band check and command line parser
//
// usage
//   item channel: one beat is either a sample tick (mode 0, 12-bit reading) or a
//   received terminal byte (mode 1). result channel: at most one beat per item.
//   a sample tick while sampling is paused is taken and gives no result beat.
//   every other item gives exactly one result beat.
// throughput
//   one item per cycle unless stalled; its result beat is in the output register
//   in the cycle after acceptance. all work of an item is one pass of shallow
//   logic (a constant multiply with a reciprocal-free divide by 4095, a threshold
//   compare, or one step of the decimal accumulator) ahead of the result register.
// stall behavior
//   item.ready is high while the result register is empty or being drained, so a
//   new item goes in in the same cycle the held beat leaves. while the receiver
//   stalls, the held beat stays put and no item is taken.
// reset
//   arst_n clears the result register, thresholds go to max 200 / min 100, the
//   report counter, line position, pause and sticky flags go to zero. the line
//   bytes are not cleared: each line rewrites them before they are read.
`default_nettype none

module temperature_threshold_monitor_top import tmon_pkg::*; #(
	parameter int LINE_BYTES      = 6,
	parameter int REPORT_INTERVAL = 5
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	tmon_item_if.sink      item,
	tmon_result_if.source  result
);

	localparam int POS_W = $clog2(LINE_BYTES + 1);
	localparam int CNT_W = (REPORT_INTERVAL > 1) ? $clog2(REPORT_INTERVAL) : 1;
	localparam int PROD_W = SAMPLE_W + TEMP_W;

	// architectural state
	logic [LIMIT_W-1:0] max_thr_q, min_thr_q;
	logic [CNT_W-1:0]   rpt_cnt_q;
	logic [POS_W-1:0]   pos_q;
	logic               paused_q;
	logic               above_q, below_q;

	// line state: key byte, latest byte, and the digit value folded so far
	// (covers positions 1 .. pos-2, the byte at pos-1 is held back since a
	// terminating CR must not be checked)
	logic [BYTE_W-1:0]  key_q;
	logic [BYTE_W-1:0]  last_q;
	logic [LIMIT_W-1:0] acc_q;
	logic               bad_q;

	// result register
	logic               out_valid_q;
	logic [EVENT_W-1:0] out_event_q;
	logic [TEMP_W-1:0]  out_temp_q;
	logic [LEVEL_W-1:0] out_level_q;
	logic               out_above_q, out_below_q;
	logic [LIMIT_W-1:0] out_max_q, out_min_q;

	logic accept;
	assign item.ready = !out_valid_q || result.ready;
	assign accept     = item.valid && item.ready;

	// sample scaling: temp = floor(s*330/4095)
	// x = q0*4096 + lo = q0*4095 + (q0 + lo), and q0 + lo < 2*4095
	logic [PROD_W-1:0]   prod;
	logic [TEMP_W-1:0]   q0;
	logic [SAMPLE_W:0]   rem;
	logic [TEMP_W-1:0]   temp;
	assign prod = PROD_W'(item.sample) * PROD_W'(SCALE_MUL);
	assign q0   = prod[PROD_W-1:SAMPLE_W];
	assign rem  = {1'b0, prod[SAMPLE_W-1:0]} + (SAMPLE_W+1)'(q0);
	assign temp = q0 + TEMP_W'(rem >= (SAMPLE_W+1)'(SCALE_DIV));

	logic [LIMIT_W-1:0] temp_ext;
	logic               is_below, is_above;
	assign temp_ext = LIMIT_W'(temp);
	assign is_below = temp_ext < min_thr_q;
	assign is_above = !is_below && (temp_ext > max_thr_q);

	logic rpt_wrap;
	assign rpt_wrap = (rpt_cnt_q == CNT_W'(REPORT_INTERVAL - 1));

	// fold of the held-back byte into the decimal value
	logic               last_digit;
	logic [3:0]         last_val;
	logic [LIMIT_W+3:0] acc_next_raw;
	logic [LIMIT_W-1:0] acc_next;
	assign last_digit   = (last_q >= CHAR_ZERO) && (last_q <= CHAR_NINE);
	assign last_val     = 4'(last_q - CHAR_ZERO);
	assign acc_next_raw = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
		+ (LIMIT_W+4)'(last_val);
	assign acc_next     = (acc_next_raw > (LIMIT_W+4)'(LIMIT_TOP)) ? LIMIT_TOP
		: acc_next_raw[LIMIT_W-1:0];

	logic line_full, pos_has_digits, line_bad;
	logic [BYTE_W-1:0] line_key;
	assign line_full      = (pos_q == POS_W'(LINE_BYTES));
	assign pos_has_digits = (pos_q > POS_W'(1));
	// a line ending at position 0 has the LF itself as key
	assign line_key       = (pos_q == '0) ? item.rx_byte : key_q;
	assign line_bad       = pos_has_digits && bad_q;

	// next-state and result decode
	logic               has_result;
	logic [EVENT_W-1:0] ev;
	logic [TEMP_W-1:0]  res_temp;
	logic [LEVEL_W-1:0] res_level;
	logic               above_d, below_d, paused_d;
	logic [LIMIT_W-1:0] max_d, min_d;
	logic [CNT_W-1:0]   cnt_d;
	logic [POS_W-1:0]   pos_d;
	logic               store_byte;

	always_comb begin
		has_result = 1'b1;
		ev         = EV_STORED;
		res_temp   = '0;
		res_level  = LVL_BELOW;
		above_d    = above_q;
		below_d    = below_q;
		paused_d   = paused_q;
		max_d      = max_thr_q;
		min_d      = min_thr_q;
		cnt_d      = rpt_cnt_q;
		pos_d      = pos_q;
		store_byte = 1'b0;
		if (item.mode == MODE_SAMPLE) begin
			if (paused_q) begin
				has_result = 1'b0;
			end else begin
				res_temp = temp;
				priority if (is_below) begin
					below_d   = 1'b1;
					res_level = LVL_BELOW;
				end else if (is_above) begin
					above_d   = 1'b1;
					res_level = LVL_ABOVE;
				end else begin
					below_d   = 1'b0;
					above_d   = 1'b0;
					res_level = LVL_BAND;
				end
				if (rpt_wrap) begin
					cnt_d = '0;
					ev    = EV_REPORT;
				end else begin
					cnt_d = rpt_cnt_q + CNT_W'(1);
					ev    = EV_SAMPLE;
				end
			end
		end else if (line_full) begin
			ev       = EV_TOO_LONG;
			pos_d    = '0;
			paused_d = 1'b0;
		end else if (item.rx_byte == CHAR_LF) begin
			pos_d    = '0;
			paused_d = 1'b0;
			priority if (line_bad) begin
				ev = EV_BAD_DIGITS;
			end else if (line_key == CHAR_MAX) begin
				max_d = pos_has_digits ? acc_q : '0;
				ev    = EV_MAX_SET;
			end else if (line_key == CHAR_MIN) begin
				min_d = pos_has_digits ? acc_q : '0;
				ev    = EV_MIN_SET;
			end else begin
				ev = EV_STORED;
			end
		end else begin
			store_byte = 1'b1;
			pos_d      = pos_q + POS_W'(1);
			if (item.rx_byte == CHAR_MAX) begin
				paused_d = 1'b1;
				ev       = EV_PROMPT_MAX;
			end else if (item.rx_byte == CHAR_MIN) begin
				paused_d = 1'b1;
				ev       = EV_PROMPT_MIN;
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_thr_q <= MAX_RESET_VAL;
			min_thr_q <= MIN_RESET_VAL;
			rpt_cnt_q <= '0;
			pos_q     <= '0;
			paused_q  <= 1'b0;
			above_q   <= 1'b0;
			below_q   <= 1'b0;
		end else if (accept) begin
			max_thr_q <= max_d;
			min_thr_q <= min_d;
			rpt_cnt_q <= cnt_d;
			pos_q     <= pos_d;
			paused_q  <= paused_d;
			above_q   <= above_d;
			below_q   <= below_d;
		end
	end

	// line bytes, rewritten by each line before use
	always_ff @(posedge clk) begin
		if (accept && store_byte) begin
			if (pos_q == '0) begin
				key_q <= item.rx_byte;
				acc_q <= '0;
				bad_q <= 1'b0;
			end else begin
				last_q <= item.rx_byte;
				if (pos_has_digits) begin
					// once a non-digit is seen the value no longer matters
					bad_q <= bad_q || !last_digit;
					acc_q <= acc_next;
				end
			end
		end
	end

	// result register, refilled while the held beat drains
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= has_result;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && has_result) begin
			out_event_q <= ev;
			out_temp_q  <= res_temp;
			out_level_q <= res_level;
			out_above_q <= above_d;
			out_below_q <= below_d;
			out_max_q   <= max_d;
			out_min_q   <= min_d;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.event_res   = out_event_q;
	assign result.temperature = out_temp_q;
	assign result.level       = out_level_q;
	assign result.max_reached = out_above_q;
	assign result.min_reached = out_below_q;
	assign result.max_limit   = out_max_q;
	assign result.min_limit   = out_min_q;

endmodule

`default_nettype wire

[rtl/tmon_checker.sv]
// port-level checker of the temperature threshold monitor and its bind
`default_nettype none

module tmon_checker import tmon_pkg::*; (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire logic               in_mode,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic [EVENT_W-1:0] event_res,
	input wire logic [TEMP_W-1:0]  temperature,
	input wire logic [LEVEL_W-1:0] level,
	input wire logic               max_reached,
	input wire logic               min_reached
);

	logic byte_beat;
	assign byte_beat = out_valid && (event_res != EV_SAMPLE) && (event_res != EV_REPORT);

	// a stalled result beat holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(event_res) && $stable(temperature)
			&& $stable(level))
		else $error("result beat changed while stalled");

	// every accepted byte gives a result beat on the next cycle
	a_byte_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_mode == MODE_BYTE) |=> out_valid)
		else $error("byte beat gave no result");

	// byte results carry no reading
	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		byte_beat |-> (temperature == '0) && (level == LVL_BELOW))
		else $error("byte result carries a reading");

	// a reading inside the band clears both sticky flags
	a_band_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !byte_beat && (level == LVL_BAND) |-> !max_reached && !min_reached)
		else $error("sticky flag survived an in-band reading");

endmodule

bind temperature_threshold_monitor_top tmon_checker u_tmon_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (item.valid),
	.in_ready   (item.ready),
	.in_mode    (item.mode),
	.out_valid  (result.valid),
	.out_ready  (result.ready),
	.event_res  (result.event_res),
	.temperature(result.temperature),
	.level      (result.level),
	.max_reached(result.max_reached),
	.min_reached(result.min_reached)
);

`default_nettype wire

[sim/tb_top.sv]
// testbench of the temperature threshold monitor: directed rows, random command lines and samples
module tb_top import tmon_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int LINE_LEN     = 6;
	localparam int REPORT_EVERY = 5;
	localparam int HOLD_AT      = 90;    // items taken before the long receiver hold-off
	localparam int HOLD_CYCLES  = 40;
	localparam int IDLE_LIMIT   = 2000;  // cycles with no beat on either channel
	localparam int PHASE_ITEMS  = 150;
	localparam int TAIL_CYCLES  = 8;

	localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0d;

	// one result beat as the monitor presents it
	typedef struct packed {
		logic [EVENT_W-1:0] ev;
		logic [TEMP_W-1:0]  temp;
		logic [LEVEL_W-1:0] level;
		logic               max_hit;
		logic               min_hit;
		logic [LIMIT_W-1:0] max_lim;
		logic [LIMIT_W-1:0] min_lim;
	} reading_t;

	// where the expected beat of a row comes from
	typedef enum logic [1:0] {
		FROM_PREDICTOR,
		TYPED_RESULT,
		TYPED_NONE
	} check_t;

	typedef struct packed {
		logic                mode;
		logic [SAMPLE_W-1:0] sample;
		logic [BYTE_W-1:0]   rx;
		check_t              src;
		reading_t            exp;
	} row_t;

	localparam reading_t UNUSED = '0;

	logic clk;
	logic arst_n;

	tmon_item_if   item_ch ();
	tmon_result_if res_ch ();

	temperature_threshold_monitor_top #(
		.LINE_BYTES     (LINE_LEN),
		.REPORT_INTERVAL(REPORT_EVERY)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item_ch),
		.result(res_ch)
	);

	// directed rows: extremes, both prompts, a paused tick, a max and a min write,
	// a line with a non-digit and a line that runs past the buffer
	row_t directed_rows [27] = '{
		// first tick after reset: 0 degrees, below the default min
		'{MODE_SAMPLE, 12'd0, 8'd0, TYPED_RESULT,
			'{EV_SAMPLE, 9'd0, LVL_BELOW, 1'b0, 1'b1, 10'd200, 10'd100}},
		// full scale: above max, below flag still sticky
		'{MODE_SAMPLE, 12'd4095, 8'd0, TYPED_RESULT,
			'{EV_SAMPLE, 9'd330, LVL_ABOVE, 1'b1, 1'b1, 10'd200, 10'd100}},
		'{MODE_SAMPLE, 12'd2048, 8'd0, FROM_PREDICTOR, UNUSED},
		'{MODE_SAMPLE, 12'd2482, 8'd0, FROM_PREDICTOR, UNUSED},  // exactly max
		'{MODE_SAMPLE, 12'd1241, 8'd0, FROM_PREDICTOR, UNUSED},  // exactly min, report tick
		'{MODE_BYTE, 12'd0, CHAR_MAX, TYPED_RESULT,
			'{EV_PROMPT_MAX, 9'd0, LVL_BELOW, 1'b0, 1'b0, 10'd200, 10'd100}},
		// tick while a line is open: swallowed
		'{MODE_SAMPLE, 12'd4095, 8'd0, TYPED_NONE, UNUSED},
		'{MODE_BYTE, 12'd0, CHAR_NINE, FROM_PREDICTOR, UNUSED},
		'{MODE_BYTE, 12'd0, CHAR_NINE, FROM_PREDICTOR, UNUSED},
		'{MODE_BYTE, 12'd0, CHAR_NINE, FROM_PREDICTOR, UNUSED},
		'{MODE_BYTE, 12'd0, CHAR_CR, FROM_PREDICTOR, UNUSED},
		'{MODE_BYTE, 12'd0, CHAR_LF, TYPED_RESULT,
			'{EV_MAX_SET, 9'd0, LVL_BELOW, 1'b0, 1'b0, 10'd999, 10'd100}},
		// min key with no digits sets zero
		'{MODE_BYTE, 12'd0, CHAR_MIN, FROM_PREDICTOR, UNUSED},
		'{MODE_BYTE, 12'd0, CHAR_LF, TYPED_RESULT,
			'{EV_MIN_SET, 9'd0, LVL_BELOW, 1'b0, 1'b0, 10'd999, 10'd0}},
		// the byte just above '9' is rejected
		'{MODE_BYTE, 12'd0, CHAR_MIN, FROM_PREDICTOR, UNUSED},
		'{MODE_BYTE, 12'd0, CHAR_ZERO, FROM_PREDICTOR, UNUSED},
		'{MODE_BYTE, 12'd0, CHAR_NINE + 8'd1, FROM_PREDICTOR, UNUSED},
		'{MODE_BYTE, 12'd0, CHAR_CR, FROM_PREDICTOR, UNUSED},
		'{MODE_BYTE, 12'd0, CHAR_LF, TYPED_RESULT,
			'{EV_BAD_DIGITS, 9'd0, LVL_BELOW, 1'b0, 1'b0, 10'd999, 10'd0}},
		// four digits: the seventh byte finds the buffer full
		'{MODE_BYTE, 12'd0, CHAR_MAX, FROM_PREDICTOR, UNUSED},
		'{MODE_BYTE, 12'd0, CHAR_ZERO + 8'd1, FROM_PREDICTOR, UNUSED},
		'{MODE_BYTE, 12'd0, CHAR_ZERO + 8'd2, FROM_PREDICTOR, UNUSED},
		'{MODE_BYTE, 12'd0, CHAR_ZERO + 8'd3, FROM_PREDICTOR, UNUSED},
		'{MODE_BYTE, 12'd0, CHAR_ZERO + 8'd4, FROM_PREDICTOR, UNUSED},
		'{MODE_BYTE, 12'd0, CHAR_CR, FROM_PREDICTOR, UNUSED},
		'{MODE_BYTE, 12'd0, 8'hff, TYPED_RESULT,
			'{EV_TOO_LONG, 9'd0, LVL_BELOW, 1'b0, 1'b0, 10'd999, 10'd0}},
		// sampling is back after the overlong line
		'{MODE_SAMPLE, 12'd4095, 8'd0, FROM_PREDICTOR, UNUSED}
	};

	// predictor state, starting at its reset values
	logic [LIMIT_W-1:0] max_thr   = MAX_RESET_VAL;
	logic [LIMIT_W-1:0] min_thr   = MIN_RESET_VAL;
	int unsigned        tick_cnt  = 0;
	int unsigned        line_pos  = 0;
	logic [BYTE_W-1:0]  line_buf [LINE_LEN];
	bit                 paused    = 1'b0;
	bit                 above     = 1'b0;
	bit                 below     = 1'b0;

	reading_t pending_events [$];  // result beats still to come, oldest first
	row_t     offered_items  [$];  // rows offered on the item channel, not yet taken
	row_t     stim_q         [$];

	int errors      = 0;
	int items_in    = 0;
	int beats_out   = 0;
	int idle_pct    = 0;
	int stall_pct   = 0;
	int hold_left   = 0;
	bit hold_done   = 1'b0;
	int quiet       = 0;
	int ev_seen [16];

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// next beat of the monitor for one item; returns 0 when the item gives none
	function automatic bit expected_event(input logic md, input logic [SAMPLE_W-1:0] s,
		input logic [BYTE_W-1:0] b, output reading_t r);
		int unsigned deg;
		int unsigned val;
		int unsigned i;
		bit bad;
		r = '0;
		if (md == MODE_SAMPLE) begin
			if (paused)
				return 1'b0;
			deg = int'(s) * SCALE_MUL / SCALE_DIV;
			// below is tested first, so min above max reads as below
			if (deg < 32'(min_thr)) begin
				below = 1'b1;
				r.level = LVL_BELOW;
			end else if (deg > 32'(max_thr)) begin
				above = 1'b1;
				r.level = LVL_ABOVE;
			end else begin
				below = 1'b0;
				above = 1'b0;
				r.level = LVL_BAND;
			end
			if (tick_cnt + 1 >= REPORT_EVERY) begin
				tick_cnt = 0;
				r.ev = EV_REPORT;
			end else begin
				tick_cnt++;
				r.ev = EV_SAMPLE;
			end
			r.temp = deg[TEMP_W-1:0];
		end else begin
			r.ev = EV_STORED;
			if (line_pos < LINE_LEN) begin
				line_buf[line_pos] = b;
				if (b == CHAR_MAX) begin
					paused = 1'b1;
					r.ev = EV_PROMPT_MAX;
					line_pos++;
				end else if (b == CHAR_MIN) begin
					paused = 1'b1;
					r.ev = EV_PROMPT_MIN;
					line_pos++;
				end else if (b == CHAR_LF) begin
					// digits sit between the key and the byte before the line feed
					val = 0;
					bad = 1'b0;
					for (i = 1; i + 1 < line_pos && i < LINE_LEN && !bad; i++) begin
						if (line_buf[i] >= CHAR_ZERO && line_buf[i] <= CHAR_NINE) begin
							val = val * 10 + int'(line_buf[i] - CHAR_ZERO);
							if (val > 32'(LIMIT_TOP))
								val = 32'(LIMIT_TOP);
						end else begin
							bad = 1'b1;
						end
					end
					if (bad) begin
						r.ev = EV_BAD_DIGITS;
					end else if (line_buf[0] == CHAR_MAX) begin
						max_thr = val[LIMIT_W-1:0];
						r.ev = EV_MAX_SET;
					end else if (line_buf[0] == CHAR_MIN) begin
						min_thr = val[LIMIT_W-1:0];
						r.ev = EV_MIN_SET;
					end
					line_pos = 0;
					paused = 1'b0;
				end else begin
					line_pos++;
				end
			end else begin
				r.ev = EV_TOO_LONG;
				line_pos = 0;
				paused = 1'b0;
			end
		end
		r.max_hit = above;
		r.min_hit = below;
		r.max_lim = max_thr;
		r.min_lim = min_thr;
		return 1'b1;
	endfunction

	function automatic void check_field(input string name, input logic [15:0] want,
		input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	// random rows; the field that the mode ignores carries noise
	function automatic row_t tick_row(input logic [SAMPLE_W-1:0] s);
		row_t r;
		r = '{MODE_SAMPLE, s, 8'($urandom_range(0, 255)), FROM_PREDICTOR, UNUSED};
		return r;
	endfunction

	function automatic row_t byte_row(input logic [BYTE_W-1:0] b);
		row_t r;
		r = '{MODE_BYTE, 12'($urandom_range(0, 4095)), b, FROM_PREDICTOR, UNUSED};
		return r;
	endfunction

	function automatic logic [SAMPLE_W-1:0] rand_sample();
		int unsigned pick;
		pick = $urandom_range(0, 7);
		if (pick == 0)
			return 12'd0;
		if (pick == 1)
			return 12'd4095;
		return 12'($urandom_range(0, 4095));
	endfunction

	// key, up to three digits, cr, lf; a broken line gets one non-digit,
	// and now and then a tick lands inside the line
	task automatic add_command(input logic [BYTE_W-1:0] key, input bit broken);
		int unsigned v;
		int unsigned nd;
		int unsigned k;
		int unsigned cut;
		bit with_tick;
		logic [BYTE_W-1:0] dig [3];
		logic [BYTE_W-1:0] junk;
		v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 999) : $urandom_range(0, 340);
		nd = (v >= 100) ? 3 : (v >= 10) ? 2 : (v > 0) ? 1 : $urandom_range(0, 1);
		if (nd < 3 && $urandom_range(0, 3) == 0)
			nd++;  // leading zero
		if (broken && nd == 0)
			nd = 1;
		for (k = 0; k < nd; k++) begin
			dig[nd - 1 - k] = CHAR_ZERO + 8'(v % 10);
			v = v / 10;
		end
		if (broken) begin
			if ($urandom_range(0, 3) == 0) begin
				junk = $urandom_range(0, 1) ? CHAR_ZERO - 8'd1 : CHAR_NINE + 8'd1;
			end else begin
				do
					junk = 8'($urandom_range(0, 255));
				while ((junk >= CHAR_ZERO && junk <= CHAR_NINE) || junk == CHAR_LF);
			end
			dig[$urandom_range(0, nd - 1)] = junk;
		end
		with_tick = ($urandom_range(0, 3) == 0);
		cut = $urandom_range(0, nd);
		stim_q.push_back(byte_row(key));
		for (k = 0; k <= nd; k++) begin
			if (with_tick && k == cut)
				stim_q.push_back(tick_row(rand_sample()));
			if (k < nd)
				stim_q.push_back(byte_row(dig[k]));
		end
		stim_q.push_back(byte_row(CHAR_CR));
		stim_q.push_back(byte_row(CHAR_LF));
	endtask

	// mostly samples and well-formed lines, the rest broken lines and noise
	task automatic build_phase(input int n);
		int unsigned pick;
		int unsigned k;
		logic [BYTE_W-1:0] key;
		stim_q.delete();
		while (stim_q.size() < n) begin
			pick = $urandom_range(0, 99);
			key = ($urandom_range(0, 1) != 0) ? CHAR_MAX : CHAR_MIN;
			if ($urandom_range(0, 9) == 0)
				key = 8'($urandom_range(0, 255));
			if (pick < 50) begin
				stim_q.push_back(tick_row(rand_sample()));
			end else if (pick < 80) begin
				add_command(key, 1'b0);
			end else if (pick < 87) begin
				add_command(key, 1'b1);
			end else if (pick < 92) begin
				// overlong line: key, five digits, then one byte too many
				stim_q.push_back(byte_row(key));
				for (k = 0; k < 5; k++)
					stim_q.push_back(byte_row(CHAR_ZERO + 8'($urandom_range(0, 9))));
				stim_q.push_back(byte_row(8'($urandom_range(0, 255))));
			end else if (pick < 94) begin
				stim_q.push_back(byte_row(CHAR_LF));
			end else begin
				stim_q.push_back(byte_row(8'($urandom_range(0, 255))));
			end
		end
	endtask

	// offer one item, with random gaps first, and hold it until taken
	task automatic send_row(input row_t r);
		while ($urandom_range(0, 99) < idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		offered_items.push_back(r);
		item_ch.valid   <= 1'b1;
		item_ch.mode    <= r.mode;
		item_ch.sample  <= r.sample;
		item_ch.rx_byte <= r.rx;
		do
			@(posedge clk);
		while (!item_ch.ready);
	endtask

	// sender pause until every expected beat has come back
	task automatic drain();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_events.size() != 0)
			@(posedge clk);
	endtask

	// receiver: random stalls, plus one long hold-off once the run is under way
	// so that the output register fills and the item channel backs up
	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (!hold_done && items_in >= HOLD_AT) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				res_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	// checker and predictor: the result beat is checked before the item taken at the
	// same edge is predicted, since an item's beat is registered and never shows at that edge
	always @(posedge clk) begin
		reading_t want;
		reading_t got;
		row_t     r;
		bit       has;
		if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			got = '{res_ch.event_res, res_ch.temperature, res_ch.level, res_ch.max_reached,
				res_ch.min_reached, res_ch.max_limit, res_ch.min_limit};
			beats_out++;
			ev_seen[got.ev]++;
			if (pending_events.size() == 0) begin
				$error("result beat with nothing expected: event %0d", got.ev);
				errors++;
			end else begin
				want = pending_events.pop_front();
				check_field("event_res", 16'(want.ev), 16'(got.ev));
				check_field("temperature", 16'(want.temp), 16'(got.temp));
				check_field("level", 16'(want.level), 16'(got.level));
				check_field("max_reached", 16'(want.max_hit), 16'(got.max_hit));
				check_field("min_reached", 16'(want.min_hit), 16'(got.min_hit));
				check_field("max_limit", 16'(want.max_lim), 16'(got.max_lim));
				check_field("min_limit", 16'(want.min_lim), 16'(got.min_lim));
			end
		end
		if (item_ch.valid === 1'b1 && item_ch.ready === 1'b1) begin
			r = offered_items.pop_front();
			has = expected_event(item_ch.mode, item_ch.sample, item_ch.rx_byte, want);
			items_in++;
			// typed rows stand on their own; the predictor still tracks the state
			if (r.src == TYPED_RESULT)
				pending_events.push_back(r.exp);
			else if (r.src == FROM_PREDICTOR && has)
				pending_events.push_back(want);
		end
	end

	// watchdog: too long without a beat on either channel ends the run
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= IDLE_LIMIT) begin
				$error("no beat for %0d cycles, %0d beats still expected",
					quiet, pending_events.size());
				$display("tb_top: errors");
				$finish;
			end
		end
	end

	initial begin
		int ph;
		item_ch.valid   = 1'b0;
		item_ch.mode    = MODE_SAMPLE;
		item_ch.sample  = '0;
		item_ch.rx_byte = '0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows, no gaps
		foreach (directed_rows[k])
			send_row(directed_rows[k]);
		drain();

		// random phases: no idling, sender gaps, receiver stalls, light both
		for (ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 75;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 75;
				end
				default: begin
					idle_pct = 6;
					stall_pct = 6;
				end
			endcase
			build_phase(PHASE_ITEMS);
			foreach (stim_q[k])
				send_row(stim_q[k]);
			drain();
		end
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("summary: %0d items taken, %0d result beats, %0d with a report",
			items_in, beats_out, ev_seen[EV_REPORT]);
		$display("summary: %0d limit writes, %0d bad lines, %0d overlong lines, %0d prompts",
			ev_seen[EV_MAX_SET] + ev_seen[EV_MIN_SET], ev_seen[EV_BAD_DIGITS],
			ev_seen[EV_TOO_LONG], ev_seen[EV_PROMPT_MAX] + ev_seen[EV_PROMPT_MIN]);
		if (errors == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule

[files.f]
rtl/tmon_pkg.sv
rtl/tmon_if.sv
rtl/temperature_threshold_monitor_top.sv
rtl/tmon_checker.sv
sim/tb_top.sv
